// ===== design/pnfe_pkg.sv =====
`default_nettype none

package pnfe_pkg;

  localparam int PANEL_WIDTH_DEF  = 256;
  localparam int PANEL_HEIGHT_DEF = 64;

  localparam int FUNC_W   = 3;
  localparam int COORD_W  = 16;
  localparam int GRAY_W   = 4;
  localparam int BADDR_W  = 13;
  localparam int BYTE_W   = 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_PIXEL  = 3'd0,
    FN_HSPAN  = 3'd1,
    FN_VSPAN  = 3'd2,
    FN_CLEAR  = 3'd3,
    FN_SCROLL = 3'd4,
    FN_READ   = 3'd5
  } func_t;

endpackage

`default_nettype wire

// ===== design/pnfe_in_if.sv =====
`default_nettype none

interface pnfe_in_if;
  logic                                      valid;
  logic                                      ready;
  logic        [pnfe_pkg::FUNC_W-1:0]        func;
  logic signed [pnfe_pkg::COORD_W-1:0]       x_pos;
  logic signed [pnfe_pkg::COORD_W-1:0]       y_pos;
  logic signed [pnfe_pkg::COORD_W-1:0]       span_length;
  logic        [pnfe_pkg::GRAY_W-1:0]        pixel_value;
  logic        [pnfe_pkg::BADDR_W-1:0]       byte_address;

  modport source (
    output valid, func, x_pos, y_pos, span_length, pixel_value, byte_address,
    input  ready
  );
  modport sink (
    input  valid, func, x_pos, y_pos, span_length, pixel_value, byte_address,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/pnfe_out_if.sv =====
`default_nettype none

interface pnfe_out_if;
  logic                              valid;
  logic                              ready;
  logic [pnfe_pkg::BYTE_W-1:0]       read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

`default_nettype wire

// ===== design/pnfe_ram.sv =====
`default_nettype none

module pnfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/pnfe_addr.sv =====
`default_nettype none

// Byte address of a pixel: row * row_bytes + col / 2
module pnfe_addr #(
  parameter int PANEL_WIDTH  = pnfe_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = pnfe_pkg::PANEL_HEIGHT_DEF,
  localparam int ROW_BYTES   = (PANEL_WIDTH + 1) / 2,
  localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT,
  localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1,
  localparam int XW          = $clog2(PANEL_WIDTH),
  localparam int YW          = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1
) (
  input  wire logic [XW-1:0] col,
  input  wire logic [YW-1:0] row,
  output logic      [AW-1:0] addr
);

  logic [AW-1:0] row_base;

  assign row_base = AW'(row) * AW'(ROW_BYTES);
  assign addr     = row_base + AW'(col >> 1);

endmodule

`default_nettype wire

// ===== design/pnfe_step.sv =====
`default_nettype none

// Shared walk counter step: next position and end-of-walk flag
module pnfe_step #(
  parameter int CW = 16
) (
  input  wire logic [CW-1:0] cur,
  input  wire logic [CW-1:0] limit,
  output logic      [CW-1:0] next,
  output logic               last
);

  assign next = cur + CW'(1);
  assign last = (next == limit);

endmodule

`default_nettype wire

// ===== design/packed_nibble_framebuffer_engine.sv =====
`default_nettype none

// 4-bit grayscale frame store, two pixels per byte (even column in the high
// nibble). One command per input beat, one read_data beat per command (zero
// unless the command is a byte read). The store sits in one RAM with one
// write and one registered read port, and every command walks it under a
// small sequencer: a pixel or a horizontal/vertical span reads and writes
// back the byte of each clipped pixel, a clear writes every byte, a scroll
// by n rows copies each kept byte up and zeroes the freed bytes (nothing for
// n <= 0), and a byte read or an unused code goes straight to its result.
// After reset the store's ROW_BYTES*PANEL_HEIGHT bytes (8192 by default) are
// zeroed before the first input beat is taken. A new command is taken while
// the previous result waits; its own result is then held back until the
// waiting result is taken.
module packed_nibble_framebuffer_engine #(
  parameter int PANEL_WIDTH  = pnfe_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = pnfe_pkg::PANEL_HEIGHT_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pnfe_in_if.sink     in_chan,
  pnfe_out_if.source  out_chan
);

  localparam int ROW_BYTES   = (PANEL_WIDTH + 1) / 2;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
  localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int XW          = $clog2(PANEL_WIDTH);
  localparam int YW          = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
  localparam int FW          = (XW > YW) ? XW : YW;
  localparam int NW_S        = $clog2(STORE_BYTES + 1);
  localparam int NW_X        = $clog2(PANEL_WIDTH + 1);
  localparam int NW_Y        = $clog2(PANEL_HEIGHT + 1);
  localparam int NW_XY       = (NW_X > NW_Y) ? NW_X : NW_Y;
  localparam int CW          = (NW_S > NW_XY) ? NW_S : NW_XY;
  localparam int CDW         = pnfe_pkg::COORD_W;
  localparam int BW          = pnfe_pkg::BYTE_W;
  localparam int GW          = pnfe_pkg::GRAY_W;

  localparam logic signed [CDW:0] LIM_X = (CDW+1)'(PANEL_WIDTH);
  localparam logic signed [CDW:0] LIM_Y = (CDW+1)'(PANEL_HEIGHT);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_SETUP, ST_SP_RD, ST_SP_WR,
    ST_SC_RD, ST_SC_WR, ST_FILL, ST_RD_DATA, ST_DONE
  } state_t;

  state_t                          state_r, state_nxt;
  logic [pnfe_pkg::FUNC_W-1:0]     func_r, func_nxt;
  logic signed [CDW-1:0]           x_r, x_nxt, y_r, y_nxt, len_r, len_nxt;
  logic [GW-1:0]                   gray_r, gray_nxt;
  logic [pnfe_pkg::BADDR_W-1:0]    baddr_r, baddr_nxt;
  logic [CW-1:0]                   cnt_r, cnt_nxt, end_r, end_nxt;
  logic [FW-1:0]                   fixed_r, fixed_nxt;
  logic                            horiz_r, horiz_nxt;
  logic [NW_S-1:0]                 off_r, off_nxt, keep_r, keep_nxt;
  logic [BW-1:0]                   fill_r, fill_nxt, res_r, res_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [BW-1:0]                   out_data_r, out_data_nxt;

  // span clip
  logic signed [CDW:0] sp_start, sp_len, sp_fixed, sp_lim, sp_flim;
  logic signed [CDW:0] sp_hi, sp_lo_c, sp_hi_c;
  logic                sp_horiz, sp_go;
  // scroll
  logic signed [CDW:0] len_ext;
  logic [NW_Y-1:0]     sc_n;
  logic [NW_S-1:0]     sc_off, sc_keep;
  // shared units
  logic [CW-1:0]       step_limit, step_next;
  logic                step_last;
  logic [XW-1:0]       pix_col;
  logic [YW-1:0]       pix_row;
  logic [AW-1:0]       pix_addr;
  logic                pix_odd;
  // ram
  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [BW-1:0]       ram_wdata, ram_rdata;

  pnfe_ram #(
    .WIDTH (BW),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pnfe_addr #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_addr (
    .col  (pix_col),
    .row  (pix_row),
    .addr (pix_addr)
  );

  pnfe_step #(
    .CW (CW)
  ) u_step (
    .cur   (cnt_r),
    .limit (step_limit),
    .next  (step_next),
    .last  (step_last)
  );

  assign in_chan.ready      = (state_r == ST_IDLE);
  assign out_chan.valid     = out_valid_r;
  assign out_chan.read_data = out_data_r;

  assign pix_col = horiz_r ? cnt_r[XW-1:0] : fixed_r[XW-1:0];
  assign pix_row = horiz_r ? fixed_r[YW-1:0] : cnt_r[YW-1:0];
  assign pix_odd = horiz_r ? cnt_r[0] : fixed_r[0];

  always_comb begin
    sp_start = {x_r[CDW-1], x_r};
    sp_len   = {len_r[CDW-1], len_r};
    sp_fixed = {y_r[CDW-1], y_r};
    sp_lim   = LIM_X;
    sp_flim  = LIM_Y;
    sp_horiz = 1'b1;
    if (func_r == pnfe_pkg::FN_PIXEL) begin
      sp_len = (CDW+1)'(1);
    end
    if (func_r == pnfe_pkg::FN_VSPAN) begin
      sp_start = {y_r[CDW-1], y_r};
      sp_fixed = {x_r[CDW-1], x_r};
      sp_lim   = LIM_Y;
      sp_flim  = LIM_X;
      sp_horiz = 1'b0;
    end
    sp_hi   = sp_start + sp_len;
    sp_lo_c = sp_start[CDW] ? '0 : sp_start;
    sp_hi_c = (sp_hi > sp_lim) ? sp_lim : sp_hi;
    sp_go   = !sp_fixed[CDW] && (sp_fixed < sp_flim) && (sp_lo_c < sp_hi_c);
  end

  always_comb begin
    len_ext = {len_r[CDW-1], len_r};
    if (len_r[CDW-1]) begin
      sc_n = '0;
    end else if (len_ext > LIM_Y) begin
      sc_n = NW_Y'(PANEL_HEIGHT);
    end else begin
      sc_n = NW_Y'(len_r);
    end
    sc_off  = NW_S'(sc_n) * NW_S'(ROW_BYTES);
    sc_keep = NW_S'(STORE_BYTES) - sc_off;
  end

  always_comb begin
    case (state_r)
      ST_SP_WR: step_limit = end_r;
      ST_SC_WR: step_limit = CW'(keep_r);
      default:  step_limit = CW'(STORE_BYTES);
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r[AW-1:0];
    ram_wdata = fill_r;
    ram_raddr = pix_addr;
    case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      ST_FILL: begin
        ram_we = 1'b1;
      end
      ST_SP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pix_addr;
        ram_wdata = pix_odd ? {ram_rdata[BW-1:GW], gray_r} : {gray_r, ram_rdata[GW-1:0]};
      end
      ST_SC_RD: begin
        ram_raddr = cnt_r[AW-1:0] + off_r[AW-1:0];
      end
      ST_SC_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      ST_SETUP: begin
        ram_raddr = AW'(baddr_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    len_nxt       = len_r;
    gray_nxt      = gray_r;
    baddr_nxt     = baddr_r;
    cnt_nxt       = cnt_r;
    end_nxt       = end_r;
    fixed_nxt     = fixed_r;
    horiz_nxt     = horiz_r;
    off_nxt       = off_r;
    keep_nxt      = keep_r;
    fill_nxt      = fill_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_INIT: begin
        cnt_nxt = step_next;
        if (step_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_chan.valid) begin
          func_nxt  = in_chan.func;
          x_nxt     = in_chan.x_pos;
          y_nxt     = in_chan.y_pos;
          len_nxt   = in_chan.span_length;
          gray_nxt  = in_chan.pixel_value;
          baddr_nxt = in_chan.byte_address;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        res_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DONE;
        unique case (func_r)
          pnfe_pkg::FN_PIXEL, pnfe_pkg::FN_HSPAN, pnfe_pkg::FN_VSPAN: begin
            if (sp_go) begin
              cnt_nxt   = CW'(sp_lo_c);
              end_nxt   = CW'(sp_hi_c);
              fixed_nxt = FW'(sp_fixed);
              horiz_nxt = sp_horiz;
              state_nxt = ST_SP_RD;
            end
          end
          pnfe_pkg::FN_CLEAR: begin
            fill_nxt  = {gray_r, gray_r};
            state_nxt = ST_FILL;
          end
          pnfe_pkg::FN_SCROLL: begin
            off_nxt  = sc_off;
            keep_nxt = sc_keep;
            fill_nxt = '0;
            if (sc_n != '0) begin
              state_nxt = (sc_keep == '0) ? ST_FILL : ST_SC_RD;
            end
          end
          pnfe_pkg::FN_READ: begin
            if (32'(baddr_r) < 32'(STORE_BYTES)) begin
              state_nxt = ST_RD_DATA;
            end
          end
          default: ;
        endcase
      end
      ST_SP_RD: begin
        state_nxt = ST_SP_WR;
      end
      ST_SP_WR: begin
        cnt_nxt   = step_next;
        state_nxt = step_last ? ST_DONE : ST_SP_RD;
      end
      ST_SC_RD: begin
        state_nxt = ST_SC_WR;
      end
      ST_SC_WR: begin
        cnt_nxt   = step_next;
        state_nxt = step_last ? ST_FILL : ST_SC_RD;
      end
      ST_FILL: begin
        cnt_nxt = step_next;
        if (step_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_RD_DATA: begin
        res_nxt   = ram_rdata;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r     <= func_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    len_r      <= len_nxt;
    gray_r     <= gray_nxt;
    baddr_r    <= baddr_nxt;
    end_r      <= end_nxt;
    fixed_r    <= fixed_nxt;
    horiz_r    <= horiz_nxt;
    off_r      <= off_nxt;
    keep_r     <= keep_nxt;
    fill_r     <= fill_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ===== tb/tb_packed_nibble_framebuffer_engine.sv =====
`timescale 1ns / 100ps

module tb_packed_nibble_framebuffer_engine;
  import pnfe_pkg::*;

  localparam int PANEL_W     = PANEL_WIDTH_DEF;
  localparam int PANEL_H     = PANEL_HEIGHT_DEF;
  localparam int ROW_BYTES   = (PANEL_W + 1) / 2;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_H;
  localparam int RANDOM_CMDS = 1900;
  localparam logic [FUNC_W-1:0] FN_SPARE6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE7 = 3'd7;

  typedef struct {
    logic        [FUNC_W-1:0]  func;
    logic signed [COORD_W-1:0] x_pos;
    logic signed [COORD_W-1:0] y_pos;
    logic signed [COORD_W-1:0] span_length;
    logic        [GRAY_W-1:0]  pixel_value;
    logic        [BADDR_W-1:0] byte_address;
    bit                        drain_first;
  } command_t;

  logic clk;
  logic rst_n;

  pnfe_in_if  in_chan ();
  pnfe_out_if out_chan ();

  packed_nibble_framebuffer_engine uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  logic [BYTE_W-1:0] frame_model [STORE_BYTES];
  logic [BYTE_W-1:0] expected_bytes [$];
  command_t          pending_cmds [$];
  command_t          cur;

  int accepted_cnt;
  int checked_cnt;
  int fail_cnt;
  int total_cmds;
  int func_seen [8];
  int gap_left;
  int burst_left;
  int clear_budget;
  int scroll_budget;
  int last_col;
  int last_row;
  logic [15:0] ready_pat;
  int          pat_age;

  initial begin
    clk = 1'b0;
  end
  always #4 clk = ~clk;

  // frame model
  function automatic void put_pixel(int col, int row, logic [GRAY_W-1:0] gray);
    int idx;
    if (col < 0 || col >= PANEL_W || row < 0 || row >= PANEL_H) return;
    idx = row * ROW_BYTES + col / 2;
    if (col % 2 == 1) frame_model[idx][3:0] = gray;
    else frame_model[idx][7:4] = gray;
  endfunction

  function automatic void fill_span(int start, int len, int limit, int fixed, int fixed_limit,
                                    bit horiz, logic [GRAY_W-1:0] gray);
    int lo;
    int hi;
    lo = start;
    hi = start + len;
    if (fixed < 0 || fixed >= fixed_limit) return;
    if (lo < 0) lo = 0;
    if (hi > limit) hi = limit;
    for (int i = lo; i < hi; i++) begin
      if (horiz) put_pixel(i, fixed, gray);
      else put_pixel(fixed, i, gray);
    end
  endfunction

  function automatic void scroll_rows(int n);
    int keep;
    if (n < 0) n = 0;
    if (n > PANEL_H) n = PANEL_H;
    if (n == 0) return;
    keep = (PANEL_H - n) * ROW_BYTES;
    for (int i = 0; i < keep; i++) frame_model[i] = frame_model[i + n * ROW_BYTES];
    for (int i = keep; i < STORE_BYTES; i++) frame_model[i] = '0;
  endfunction

  function automatic logic [BYTE_W-1:0] apply_command(command_t c);
    int x;
    int y;
    int len;
    logic [BYTE_W-1:0] rd;
    x   = c.x_pos;
    y   = c.y_pos;
    len = c.span_length;
    rd  = '0;
    case (c.func)
      FN_PIXEL:  put_pixel(x, y, c.pixel_value);
      FN_HSPAN:  fill_span(x, len, PANEL_W, y, PANEL_H, 1'b1, c.pixel_value);
      FN_VSPAN:  fill_span(y, len, PANEL_H, x, PANEL_W, 1'b0, c.pixel_value);
      FN_CLEAR: begin
        for (int i = 0; i < STORE_BYTES; i++) frame_model[i] = {c.pixel_value, c.pixel_value};
      end
      FN_SCROLL: scroll_rows(len);
      FN_READ: begin
        if (c.byte_address < STORE_BYTES) rd = frame_model[c.byte_address];
      end
      default: rd = '0;
    endcase
    return rd;
  endfunction

  // stimulus construction
  function automatic command_t make_cmd(logic [FUNC_W-1:0] f, int x, int y, int len, int gray,
                                        int addr, bit drain = 1'b0);
    command_t c;
    c.func         = f;
    c.x_pos        = x[15:0];
    c.y_pos        = y[15:0];
    c.span_length  = len[15:0];
    c.pixel_value  = gray[3:0];
    c.byte_address = addr[12:0];
    c.drain_first  = drain;
    return c;
  endfunction

  function automatic int rand_coord(int lo, int hi);
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(65535, 0)) - 32768;
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  function automatic int rand_span_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(0, 24);
    if (r < 15) return $urandom_range(0, 300);
    if (r < 17) return -int'($urandom_range(1, 40));
    return int'($urandom_range(65535, 0)) - 32768;
  endfunction

  function automatic int rand_scroll_count();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(40, 64);
    if (r < 6) return $urandom_range(65, 32767);
    if (r < 8) return -int'($urandom_range(0, 32768));
    return $urandom_range(1, 39);
  endfunction

  function automatic int recent_address();
    int col;
    int row;
    col = (last_col < 0) ? 0 : (last_col >= PANEL_W) ? PANEL_W - 1 : last_col;
    row = (last_row < 0) ? 0 : (last_row >= PANEL_H) ? PANEL_H - 1 : last_row;
    return row * ROW_BYTES + col / 2;
  endfunction

  function automatic void push_cmd(command_t c);
    pending_cmds.push_back(c);
    total_cmds++;
  endfunction

  // driver
  always @(posedge clk) begin
    bit took;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      accepted_cnt  <= 0;
      gap_left      = 0;
      burst_left    = 1;
    end else begin
      took = in_chan.valid && in_chan.ready;
      if (took) begin
        expected_bytes.push_back(apply_command(cur));
        func_seen[cur.func]++;
      end
      accepted_cnt <= accepted_cnt + int'(took);
      if (!in_chan.valid || in_chan.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_chan.valid <= 1'b0;
        end else if (pending_cmds.size() == 0) begin
          in_chan.valid <= 1'b0;
        end else if (pending_cmds[0].drain_first && (took || checked_cnt != accepted_cnt)) begin
          in_chan.valid <= 1'b0;
        end else begin
          cur = pending_cmds.pop_front();
          in_chan.valid        <= 1'b1;
          in_chan.func         <= cur.func;
          in_chan.x_pos        <= cur.x_pos;
          in_chan.y_pos        <= cur.y_pos;
          in_chan.span_length  <= cur.span_length;
          in_chan.pixel_value  <= cur.pixel_value;
          in_chan.byte_address <= cur.byte_address;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      ready_pat      <= 16'hFFFF;
      pat_age        <= 0;
    end else begin
      out_chan.ready <= ready_pat[0];
      if (pat_age == 255) begin
        ready_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0101);
      end else begin
        ready_pat <= {ready_pat[0], ready_pat[15:1]};
      end
      pat_age <= (pat_age + 1) % 256;
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [BYTE_W-1:0] want;
    if (!rst_n) begin
      checked_cnt <= 0;
    end else if (out_chan.valid && out_chan.ready) begin
      if (expected_bytes.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("%0t: unexpected result beat, read_data=%02h", $realtime, out_chan.read_data);
      end else begin
        want = expected_bytes.pop_front();
        if (out_chan.read_data !== want) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: result %0d read_data mismatch: expected %02h, got %02h",
                     $realtime, checked_cnt, want, out_chan.read_data);
        end
      end
      checked_cnt <= checked_cnt + 1;
    end
  end

  initial begin
    #50_000_000;
    $display("packed_nibble_framebuffer_engine regression: fail");
    $finish;
  end

  initial begin
    int pick;
    int n_rand;
    int x;
    int y;
    command_t c;
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.func         = '0;
    in_chan.x_pos        = '0;
    in_chan.y_pos        = '0;
    in_chan.span_length  = '0;
    in_chan.pixel_value  = '0;
    in_chan.byte_address = '0;
    out_chan.ready       = 1'b0;
    fail_cnt             = 0;
    total_cmds           = 0;
    clear_budget         = 14;
    scroll_budget        = 24;
    last_col             = 0;
    last_row             = 0;
    foreach (func_seen[i]) func_seen[i] = 0;
    foreach (frame_model[i]) frame_model[i] = '0;

    // directed
    push_cmd(make_cmd(FN_READ, 0, 0, 0, 0, 0));
    push_cmd(make_cmd(FN_PIXEL, 0, 0, 0, 15, 0));
    push_cmd(make_cmd(FN_PIXEL, 1, 0, 0, 5, 0));
    push_cmd(make_cmd(FN_PIXEL, 255, 63, 0, 10, 0));
    push_cmd(make_cmd(FN_PIXEL, -1, 0, 0, 3, 0));
    push_cmd(make_cmd(FN_PIXEL, 256, 0, 0, 3, 0));
    push_cmd(make_cmd(FN_PIXEL, 0, 64, 0, 3, 0));
    push_cmd(make_cmd(FN_PIXEL, -32768, 32767, 0, 3, 0));
    push_cmd(make_cmd(FN_READ, 0, 0, 0, 0, 0));
    push_cmd(make_cmd(FN_READ, 0, 0, 0, 0, STORE_BYTES - 1));
    push_cmd(make_cmd(FN_HSPAN, -10, 5, 20, 3, 0));
    push_cmd(make_cmd(FN_HSPAN, 250, 6, 32767, 7, 0));
    push_cmd(make_cmd(FN_HSPAN, 32767, 7, -32768, 2, 0));
    push_cmd(make_cmd(FN_HSPAN, 0, 64, 5, 2, 0));
    push_cmd(make_cmd(FN_VSPAN, 3, -5, 100, 9, 0));
    push_cmd(make_cmd(FN_VSPAN, 256, 0, 10, 9, 0));
    push_cmd(make_cmd(FN_READ, 0, 0, 0, 0, 5 * ROW_BYTES));
    push_cmd(make_cmd(FN_READ, 0, 0, 0, 0, 6 * ROW_BYTES + ROW_BYTES - 1, 1'b1));
    push_cmd(make_cmd(FN_SCROLL, 0, 0, 0, 0, 0));
    push_cmd(make_cmd(FN_SCROLL, 0, 0, -32768, 0, 0));
    push_cmd(make_cmd(FN_SCROLL, 0, 0, 1, 0, 0));
    push_cmd(make_cmd(FN_READ, 0, 0, 0, 0, 4 * ROW_BYTES + 1));
    push_cmd(make_cmd(FN_SCROLL, 0, 0, 63, 0, 0));
    push_cmd(make_cmd(FN_SCROLL, 0, 0, 32767, 0, 0));
    push_cmd(make_cmd(FN_CLEAR, 0, 0, 0, 12, 0));
    push_cmd(make_cmd(FN_READ, 0, 0, 0, 0, STORE_BYTES - 1));
    push_cmd(make_cmd(FN_SPARE6, -1, -1, -1, 15, 8191));
    push_cmd(make_cmd(FN_SPARE7, 0, 0, 0, 0, 0));

    // random: each draw followed, on a coin toss, by a readback near the drawn position
    n_rand = 0;
    while (n_rand < RANDOM_CMDS) begin
      pick = $urandom_range(0, 999);
      c = make_cmd(FN_READ, rand_coord(-300, 300), rand_coord(-300, 300),
                   int'($urandom_range(65535, 0)) - 32768, $urandom_range(0, 15),
                   $urandom_range(STORE_BYTES - 1, 0));
      if (pick < 350) begin
        c.func  = FN_PIXEL;
        x       = rand_coord(-4, PANEL_W + 3);
        y       = rand_coord(-2, PANEL_H + 1);
        c.x_pos = x[15:0];
        c.y_pos = y[15:0];
      end else if (pick < 500) begin
        c.func        = FN_HSPAN;
        x             = rand_coord(-30, PANEL_W + 14);
        y             = rand_coord(-3, PANEL_H + 2);
        c.x_pos       = x[15:0];
        c.y_pos       = y[15:0];
        c.span_length = 16'(rand_span_len());
      end else if (pick < 600) begin
        c.func        = FN_VSPAN;
        x             = rand_coord(-3, PANEL_W + 2);
        y             = rand_coord(-20, PANEL_H + 6);
        c.x_pos       = x[15:0];
        c.y_pos       = y[15:0];
        c.span_length = 16'(rand_span_len());
      end else if (pick < 610 && clear_budget > 0) begin
        c.func = FN_CLEAR;
        clear_budget--;
      end else if (pick < 625 && scroll_budget > 0) begin
        c.func        = FN_SCROLL;
        c.span_length = 16'(rand_scroll_count());
        scroll_budget--;
      end else if (pick >= 625 && pick < 645) begin
        c.func = pick[0] ? FN_SPARE7 : FN_SPARE6;
      end else if (pick < 800) begin
        c.byte_address = 13'(recent_address());
      end
      if (n_rand % 400 == 399) c.drain_first = 1'b1;
      push_cmd(c);
      n_rand++;
      if (c.func == FN_PIXEL || c.func == FN_HSPAN || c.func == FN_VSPAN) begin
        last_col = c.x_pos;
        last_row = c.y_pos;
        if (c.func == FN_HSPAN && c.span_length > 0) last_col += $urandom_range(0, 3);
        if (c.func == FN_VSPAN && c.span_length > 0) last_row += $urandom_range(0, 3);
        if ($urandom_range(0, 1) == 1) begin
          push_cmd(make_cmd(FN_READ, 0, 0, 0, 0, recent_address()));
          n_rand++;
        end
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (accepted_cnt != total_cmds || checked_cnt != accepted_cnt);
    repeat (20) @(posedge clk);

    if (expected_bytes.size() != 0) begin
      fail_cnt++;
      $display("%0d expected results never arrived", expected_bytes.size());
    end
    $display("covered %0d commands: %0d pixel, %0d hspan, %0d vspan, %0d clear, %0d scroll,",
             accepted_cnt, func_seen[FN_PIXEL], func_seen[FN_HSPAN], func_seen[FN_VSPAN],
             func_seen[FN_CLEAR], func_seen[FN_SCROLL]);
    $display("  %0d byte reads, %0d unused codes; %0d result beats checked, %0d failures",
             func_seen[FN_READ], func_seen[FN_SPARE6] + func_seen[FN_SPARE7], checked_cnt,
             fail_cnt);
    if (fail_cnt == 0) begin
      $display("packed_nibble_framebuffer_engine regression: pass");
    end else begin
      $display("packed_nibble_framebuffer_engine regression: fail");
    end
    $finish;
  end

endmodule
